### rtl/gtd_pkg.sv
// ----------------------------------------------------------------------------
// gtd_pkg
// Shared types, constants and tables of the Goertzel tone detector.
// ----------------------------------------------------------------------------
package gtd_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int MAX_FRAME_DEF = 4096;
    localparam int CFG_W         = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int ACC_W         = 64;
    localparam int MUL_W         = 33;
    localparam int PROD_W        = 2 * MUL_W;
    localparam int PSUM_W        = 98;
    localparam int RE_W          = 69;
    localparam int AMP_W         = 32;
    localparam int PHASE_W       = 16;
    localparam int Z_W           = 19;
    localparam int ANG_W         = 14;
    localparam int CORDIC_STEPS  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COS_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_W = 2'd1;

    localparam logic signed [CFG_W-1:0] COS_W_RESET = 32'sd1073741824;
    localparam logic signed [CFG_W-1:0] SIN_W_RESET = 32'sd0;

    localparam logic signed [PHASE_W-1:0] PI_Q13      = 16'sd25736;
    localparam logic [ANG_W-1:0]          HALF_PI_Q13 = 14'd12868;
    localparam logic signed [Z_W-1:0]     HALF_PI_Q16 = 19'sd102944;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_in_beat;

    typedef struct packed {
        logic [AMP_W-1:0]          amplitude;
        logic signed [PHASE_W-1:0] phase;
    } t_out_beat;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MLO,
        F_MHI,
        F_SUM,
        F_UPD,
        F_PUSH
    } t_front_state;

    typedef enum logic [4:0] {
        B_IDLE,
        B_CLO,
        B_CHI,
        B_CSUM,
        B_SLO,
        B_SHI,
        B_SSUM,
        B_ABS,
        B_CHK,
        B_SQ1,
        B_SQ2,
        B_NSQ,
        B_SUM,
        B_CMP,
        B_DIV,
        B_SQR,
        B_PZ,
        B_NR,
        B_NL,
        B_CORD,
        B_ANG,
        B_OUT
    } t_back_state;

    // arctan(2^-i) in Q16
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [3:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            4'd0:    v = 19'sd51472;
            4'd1:    v = 19'sd30386;
            4'd2:    v = 19'sd16055;
            4'd3:    v = 19'sd8150;
            4'd4:    v = 19'sd4091;
            4'd5:    v = 19'sd2047;
            4'd6:    v = 19'sd1024;
            4'd7:    v = 19'sd512;
            4'd8:    v = 19'sd256;
            4'd9:    v = 19'sd128;
            4'd10:   v = 19'sd64;
            4'd11:   v = 19'sd32;
            4'd12:   v = 19'sd16;
            4'd13:   v = 19'sd8;
            4'd14:   v = 19'sd4;
            4'd15:   v = 19'sd2;
            default: v = 19'sd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/goertzel_tone_detector.sv
// ----------------------------------------------------------------------------
// goertzel_tone_detector
// Single-bin Goertzel detector with amplitude and phase per frame.
// ----------------------------------------------------------------------------
// Samples enter through a queue-style port (push/full) and results leave
// through one (empty/pop). Each sample goes through the front end in order:
// the state that takes the beat, then the 64x32 recurrence product formed as
// two 33x33 partial products, summed, then added and saturated; the port stays
// full until the sample is done. The sample marked last then hands its frame
// state to a two-entry frame queue. The back end then works one frame at a
// time on a single shared multiplier: real and imaginary parts, a 98-step
// restoring divider and a 32-step square root for the amplitude, one-bit
// normalisation and 16 CORDIC steps for the phase; frames that arrive faster
// than the back end finishes them back up in the frame queue and then stall
// the sample port. Results wait in a two-entry output queue. cos_w (index 0)
// and sin_w (index 1) are Q2.30 and should be written only while the block
// is idle; writes to other indexes are dropped.
// ----------------------------------------------------------------------------
module goertzel_tone_detector
    import gtd_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  t_in_beat             i_in,
    output logic                 empty,
    input  logic                 pop,
    output t_out_beat            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int FRM_W = 2 * ACC_W + CNT_W;
    localparam int RES_W = $bits(t_out_beat);

    logic signed [CFG_W-1:0] r_cos_w;
    logic signed [CFG_W-1:0] r_sin_w;

    logic             w_frm_push;
    logic [FRM_W-1:0] w_frm_wdata;
    logic             w_frm_full;
    logic             w_frm_pop;
    logic [FRM_W-1:0] w_frm_rdata;
    logic             w_frm_empty;
    logic             w_res_push;
    t_out_beat        w_res;
    logic             w_res_full;
    logic [RES_W-1:0] w_res_rdata;

    // configuration registers: take the beat straight away
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_w <= COS_W_RESET;
            r_sin_w <= SIN_W_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_COS_W) begin
                r_cos_w <= i_cfg_data;
            end else if (i_cfg_idx == CFG_SIN_W) begin
                r_sin_w <= i_cfg_data;
            end
        end
    end

    // front end: recurrence per sample, frame state out on the last one
    gtd_front #(
        .MAX_FRAME (MAX_FRAME),
        .CNT_W     (CNT_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_in       (i_in),
        .i_cos_w    (r_cos_w),
        .o_frm_push (w_frm_push),
        .o_frm      (w_frm_wdata),
        .i_frm_full (w_frm_full)
    );

    // hold finished frames so the front can start the next one
    gtd_fifo #(
        .W     (FRM_W),
        .DEPTH (2)
    ) u_frm_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_frm_push),
        .i_wdata (w_frm_wdata),
        .o_full  (w_frm_full),
        .i_pop   (w_frm_pop),
        .o_rdata (w_frm_rdata),
        .o_empty (w_frm_empty)
    );

    // back end: end-of-frame maths
    gtd_back #(
        .MAX_FRAME (MAX_FRAME),
        .CNT_W     (CNT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frm_empty (w_frm_empty),
        .o_frm_pop   (w_frm_pop),
        .i_frm       (w_frm_rdata),
        .i_cos_w     (r_cos_w),
        .i_sin_w     (r_sin_w),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .i_res_full  (w_res_full)
    );

    // result queue: the oldest beat sits on o_out while empty is low
    gtd_fifo #(
        .W     (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_wdata (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_rdata (w_res_rdata),
        .o_empty (empty)
    );

    assign o_out = t_out_beat'(w_res_rdata);

endmodule

### rtl/gtd_fifo.sv
// ----------------------------------------------------------------------------
// gtd_fifo
// Small first-word-fall-through register queue.
// ----------------------------------------------------------------------------
module gtd_fifo
    import gtd_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_do_push;
    logic          w_do_pop;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_rdata   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_mem[r_wr] <= i_wdata;
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/gtd_front.sv
// ----------------------------------------------------------------------------
// gtd_front
// Sample front end: runs the Goertzel recurrence and hands finished frames on.
// ----------------------------------------------------------------------------
module gtd_front
    import gtd_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF,
    parameter int CNT_W     = $clog2(MAX_FRAME + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_full,
    input  t_in_beat                i_in,
    input  logic signed [CFG_W-1:0] i_cos_w,
    output logic                    o_frm_push,
    output logic [2*ACC_W+CNT_W-1:0] o_frm,
    input  logic                    i_frm_full
);

    t_front_state              r_state;
    t_front_state              n_state;
    logic signed [ACC_W-1:0]   r_s1;
    logic signed [ACC_W-1:0]   r_s2;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                      r_last;
    logic signed [PROD_W-1:0]  r_p0;
    logic signed [PROD_W-1:0]  r_p1;
    logic signed [RE_W-1:0]    r_t;

    logic signed [MUL_W-1:0]   w_mul_a;
    logic signed [MUL_W-1:0]   w_cos;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PSUM_W-1:0]  w_psum;
    logic signed [RE_W+1:0]    w_v;
    logic signed [ACC_W-1:0]   w_sat;

    assign w_cos   = MUL_W'(i_cos_w);
    assign w_mul_a = (r_state == F_MLO) ? $signed({1'b0, r_s1[31:0]})
                                        : $signed({r_s1[63], r_s1[63:32]});
    assign w_prod  = w_mul_a * w_cos;

    // 2*cos*s1 / 2^30 with round half up
    assign w_psum = (PSUM_W'(r_p1) <<< 32) + PSUM_W'(r_p0) + PSUM_W'(64'sd268435456);

    assign w_v = (RE_W+2)'(r_t) + (RE_W+2)'(r_x) - (RE_W+2)'(r_s2);

    always_comb begin
        if ((&w_v[RE_W+1:ACC_W-1]) || !(|w_v[RE_W+1:ACC_W-1])) begin
            w_sat = w_v[ACC_W-1:0];
        end else if (w_v[RE_W+1]) begin
            w_sat = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

    assign o_full = (r_state != F_IDLE) || !i_rst_n;
    assign o_frm  = {r_s1, r_s2, r_cnt};

    always_comb begin
        n_state    = r_state;
        o_frm_push = 1'b0;
        case (r_state)
            F_IDLE: if (i_push) n_state = F_MLO;
            F_MLO:  n_state = F_MHI;
            F_MHI:  n_state = F_SUM;
            F_SUM:  n_state = F_UPD;
            F_UPD:  n_state = r_last ? F_PUSH : F_IDLE;
            F_PUSH: begin
                if (!i_frm_full) begin
                    o_frm_push = 1'b1;
                    n_state    = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_s1    <= '0;
            r_s2    <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        r_x    <= i_in.sample;
                        r_last <= i_in.last;
                    end
                end
                F_MLO: r_p0 <= w_prod;
                F_MHI: r_p1 <= w_prod;
                F_SUM: r_t  <= w_psum[PSUM_W-1:29];
                F_UPD: begin
                    r_s2 <= r_s1;
                    r_s1 <= w_sat;
                    if (r_cnt < CNT_W'(MAX_FRAME)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                F_PUSH: begin
                    if (!i_frm_full) begin
                        r_s1  <= '0;
                        r_s2  <= '0;
                        r_cnt <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

### rtl/gtd_back.sv
// ----------------------------------------------------------------------------
// gtd_back
// Frame back end: real/imag, amplitude by division and square root, phase by
// CORDIC, all on one shared multiplier and iterative units.
// ----------------------------------------------------------------------------
module gtd_back
    import gtd_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF,
    parameter int CNT_W     = $clog2(MAX_FRAME + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_frm_empty,
    output logic                     o_frm_pop,
    input  logic [2*ACC_W+CNT_W-1:0] i_frm,
    input  logic signed [CFG_W-1:0]  i_cos_w,
    input  logic signed [CFG_W-1:0]  i_sin_w,
    output logic                     o_res_push,
    output t_out_beat                o_res,
    input  logic                     i_res_full
);

    localparam int D_W   = 2 * CNT_W;
    localparam int DVD_W = 98;

    t_back_state              r_state;
    t_back_state              n_state;
    logic signed [ACC_W-1:0]  r_s1;
    logic signed [ACC_W-1:0]  r_s2;
    logic [CNT_W-1:0]         r_n;
    logic signed [PROD_W-1:0] r_p0;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [RE_W-2:0]   r_rc;
    logic signed [RE_W-1:0]   r_re;
    logic signed [RE_W-1:0]   r_im;
    logic [RE_W-1:0]          r_are;
    logic [RE_W-1:0]          r_aim;
    logic                     r_re_neg;
    logic                     r_im_neg;
    logic [D_W-1:0]           r_d;
    logic [ACC_W-1:0]         r_s;
    logic [DVD_W-1:0]         r_dvd;
    logic [D_W-1:0]           r_rem;
    logic [ACC_W-1:0]         r_q;
    logic [AMP_W-1:0]         r_root;
    logic [AMP_W+1:0]         r_srem;
    logic [AMP_W-1:0]         r_amp;
    logic [RE_W-1:0]          r_x;
    logic [RE_W-1:0]          r_y;
    logic signed [MUL_W-1:0]  r_cx;
    logic signed [MUL_W-1:0]  r_cy;
    logic signed [Z_W-1:0]    r_z;
    logic [ANG_W-1:0]         r_ang;
    logic [6:0]               r_cnt;

    logic signed [MUL_W-1:0]  w_mul_a;
    logic signed [MUL_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PSUM_W-1:0] w_psum;
    logic [RE_W-1:0]          w_lim;
    logic [D_W:0]             w_rem2;
    logic [AMP_W+3:0]         w_srem2;
    logic [AMP_W+3:0]         w_trial;
    logic signed [MUL_W-1:0]  w_sx;
    logic signed [MUL_W-1:0]  w_sy;
    logic signed [Z_W-1:0]    w_zc;
    logic signed [PHASE_W-1:0] w_ph0;
    logic signed [PHASE_W-1:0] w_ph;

    // shared 33x33 multiplier, operands by step
    always_comb begin
        case (r_state)
            B_CLO:   begin w_mul_a = $signed({1'b0, r_s2[31:0]});   w_mul_b = MUL_W'(i_cos_w); end
            B_CHI:   begin w_mul_a = $signed({r_s2[63], r_s2[63:32]}); w_mul_b = MUL_W'(i_cos_w); end
            B_SLO:   begin w_mul_a = $signed({1'b0, r_s2[31:0]});   w_mul_b = MUL_W'(i_sin_w); end
            B_SHI:   begin w_mul_a = $signed({r_s2[63], r_s2[63:32]}); w_mul_b = MUL_W'(i_sin_w); end
            B_SQ1:   begin w_mul_a = $signed({1'b0, r_are[31:0]});  w_mul_b = $signed({1'b0, r_are[31:0]}); end
            B_SQ2:   begin w_mul_a = $signed({1'b0, r_aim[31:0]});  w_mul_b = $signed({1'b0, r_aim[31:0]}); end
            B_NSQ:   begin w_mul_a = $signed(MUL_W'(r_n));           w_mul_b = $signed(MUL_W'(r_n)); end
            default: begin w_mul_a = '0;                             w_mul_b = '0; end
        endcase
    end
    assign w_prod = w_mul_a * w_mul_b;

    // product / 2^30, round half up
    assign w_psum = (PSUM_W'(r_p1) <<< 32) + PSUM_W'(r_p0) + PSUM_W'(64'sd536870912);

    assign w_lim = RE_W'(r_n) << 15;

    // restoring division step
    assign w_rem2 = {r_rem, r_dvd[DVD_W-1]};

    // square root digit step
    assign w_srem2 = {r_srem, r_q[ACC_W-1:ACC_W-2]};
    assign w_trial = (AMP_W+4)'({r_root, 2'b01});

    // CORDIC vectoring step
    assign w_sx = r_cx >>> r_cnt[3:0];
    assign w_sy = r_cy >>> r_cnt[3:0];

    always_comb begin
        if (r_z < 0) begin
            w_zc = '0;
        end else if (r_z > HALF_PI_Q16) begin
            w_zc = HALF_PI_Q16;
        end else begin
            w_zc = r_z;
        end
    end

    // restore quadrant
    assign w_ph0 = r_re_neg ? (PI_Q13 - PHASE_W'(r_ang)) : PHASE_W'(r_ang);
    assign w_ph  = r_im_neg ? -w_ph0 : w_ph0;

    assign o_res.amplitude = r_amp;
    assign o_res.phase     = w_ph;

    always_comb begin
        n_state    = r_state;
        o_frm_pop  = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_frm_empty) begin
                    o_frm_pop = 1'b1;
                    n_state   = B_CLO;
                end
            end
            B_CLO:  n_state = B_CHI;
            B_CHI:  n_state = B_CSUM;
            B_CSUM: n_state = B_SLO;
            B_SLO:  n_state = B_SHI;
            B_SHI:  n_state = B_SSUM;
            B_SSUM: n_state = B_ABS;
            B_ABS:  n_state = B_CHK;
            B_CHK:  n_state = ((r_are >= w_lim) || (r_aim >= w_lim)) ? B_PZ : B_SQ1;
            B_SQ1:  n_state = B_SQ2;
            B_SQ2:  n_state = B_NSQ;
            B_NSQ:  n_state = B_SUM;
            B_SUM:  n_state = B_CMP;
            B_CMP:  n_state = ((ACC_W+D_W)'(r_s) >= ((ACC_W+D_W)'(r_d) << 30)) ? B_PZ : B_DIV;
            B_DIV:  if (r_cnt == '0) n_state = B_SQR;
            B_SQR:  if (r_cnt == '0) n_state = B_PZ;
            B_PZ: begin
                if ((r_aim == '0) || (r_are == '0)) begin
                    n_state = B_OUT;
                end else begin
                    n_state = B_NR;
                end
            end
            B_NR:   if (!(|(r_x[RE_W-1:30] | r_y[RE_W-1:30]))) n_state = B_NL;
            B_NL:   if (r_x[29] || r_y[29]) n_state = B_CORD;
            B_CORD: if (r_cnt == 7'(CORDIC_STEPS - 1)) n_state = B_ANG;
            B_ANG:  n_state = B_OUT;
            B_OUT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
            case (r_state)
                B_IDLE: begin
                    if (!i_frm_empty) begin
                        r_s1 <= i_frm[2*ACC_W+CNT_W-1:ACC_W+CNT_W];
                        r_s2 <= i_frm[ACC_W+CNT_W-1:CNT_W];
                        r_n  <= i_frm[CNT_W-1:0];
                    end
                end
                B_CLO:  r_p0 <= w_prod;
                B_CHI:  r_p1 <= w_prod;
                B_CSUM: r_rc <= w_psum[PSUM_W-1:30];
                B_SLO: begin
                    r_p0 <= w_prod;
                    r_re <= RE_W'(r_s1) - RE_W'(r_rc);
                end
                B_SHI:  r_p1 <= w_prod;
                B_SSUM: r_im <= RE_W'($signed(w_psum[PSUM_W-1:30]));
                B_ABS: begin
                    r_are    <= r_re[RE_W-1] ? RE_W'(-r_re) : RE_W'(r_re);
                    r_aim    <= r_im[RE_W-1] ? RE_W'(-r_im) : RE_W'(r_im);
                    r_re_neg <= r_re[RE_W-1];
                    r_im_neg <= r_im[RE_W-1];
                end
                B_CHK: begin
                    if ((r_are >= w_lim) || (r_aim >= w_lim)) begin
                        r_amp <= '1;
                    end
                end
                B_SQ1:  r_p0 <= w_prod;
                B_SQ2:  r_p1 <= w_prod;
                B_NSQ:  r_d  <= w_prod[D_W-1:0];
                B_SUM:  r_s  <= r_p0[ACC_W-1:0] + r_p1[ACC_W-1:0];
                B_CMP: begin
                    if ((ACC_W+D_W)'(r_s) >= ((ACC_W+D_W)'(r_d) << 30)) begin
                        r_amp <= '1;
                    end else begin
                        r_dvd <= {r_s, 34'd0};
                        r_rem <= '0;
                        r_cnt <= 7'(DVD_W - 1);
                    end
                end
                B_DIV: begin
                    r_dvd <= r_dvd << 1;
                    if (w_rem2 >= (D_W+1)'(r_d)) begin
                        r_rem <= D_W'(w_rem2 - (D_W+1)'(r_d));
                        r_q   <= {r_q[ACC_W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rem2[D_W-1:0];
                        r_q   <= {r_q[ACC_W-2:0], 1'b0};
                    end
                    if (r_cnt == '0) begin
                        r_root <= '0;
                        r_srem <= '0;
                        r_cnt  <= 7'(AMP_W - 1);
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                B_SQR: begin
                    r_q <= r_q << 2;
                    if (w_srem2 >= w_trial) begin
                        r_srem <= (AMP_W+2)'(w_srem2 - w_trial);
                        r_root <= {r_root[AMP_W-2:0], 1'b1};
                        if (r_cnt == '0) r_amp <= {r_root[AMP_W-2:0], 1'b1};
                    end else begin
                        r_srem <= w_srem2[AMP_W+1:0];
                        r_root <= {r_root[AMP_W-2:0], 1'b0};
                        if (r_cnt == '0) r_amp <= {r_root[AMP_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 1'b1;
                end
                B_PZ: begin
                    if (r_aim == '0) begin
                        r_ang <= '0;
                    end else if (r_are == '0) begin
                        r_ang <= HALF_PI_Q13;
                    end
                    r_x <= r_are;
                    r_y <= r_aim;
                end
                B_NR: begin
                    if (|(r_x[RE_W-1:30] | r_y[RE_W-1:30])) begin
                        r_x <= r_x >> 1;
                        r_y <= r_y >> 1;
                    end
                end
                B_NL: begin
                    if (!r_x[29] && !r_y[29]) begin
                        r_x <= r_x << 1;
                        r_y <= r_y << 1;
                    end else begin
                        r_cx  <= $signed(MUL_W'(r_x[29:0]));
                        r_cy  <= $signed(MUL_W'(r_y[29:0]));
                        r_z   <= '0;
                        r_cnt <= '0;
                    end
                end
                B_CORD: begin
                    if (!r_cy[MUL_W-1]) begin
                        r_cx <= r_cx + w_sy;
                        r_cy <= r_cy - w_sx;
                        r_z  <= r_z + atan_q16(r_cnt[3:0]);
                    end else begin
                        r_cx <= r_cx - w_sy;
                        r_cy <= r_cy + w_sx;
                        r_z  <= r_z - atan_q16(r_cnt[3:0]);
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                B_ANG: r_ang <= ANG_W'((w_zc + Z_W'(4)) >>> 3);
                default: ;
            endcase
        end
    end

endmodule
